>>> design/bcdclk_pkg.sv
// Shared types, action codes and digit functions for the BCD alarm clock.
package bcdclk_pkg;

  localparam int DigitCount = 6;
  localparam int TpsWidth   = 32;
  localparam int SnzWidth   = 8;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_SET_TIME  = 3'd1,
    ACT_SET_ALARM = 3'd2,
    ACT_ALARM_EN  = 3'd3,
    ACT_SET_SNZ   = 3'd4
  } action_t;

  // Index 0 is the hour tens digit, index 5 the second units digit.
  typedef logic [0:DigitCount-1][3:0] digits_t;

  typedef struct packed {
    logic [2:0]          action;
    logic [3:0]          hour_tens;
    logic [3:0]          hour_units;
    logic [3:0]          minute_tens;
    logic [3:0]          minute_units;
    logic [3:0]          second_tens;
    logic [3:0]          second_units;
    logic                enable_value;
    logic [SnzWidth-1:0] snooze_seconds;
  } in_item_t;

  typedef struct packed {
    logic [3:0] now_hour_tens;
    logic [3:0] now_hour_units;
    logic [3:0] now_minute_tens;
    logic [3:0] now_minute_units;
    logic [3:0] now_second_tens;
    logic [3:0] now_second_units;
    logic       time_valid;
    logic       alarm_enabled;
    logic       ringing;
    logic       rejected;
  } out_item_t;

  function automatic logic digits_ok(digits_t d);
    logic ok;
    ok = 1'b1;
    if (d[0] > 4'd2 || d[1] > 4'd9) ok = 1'b0;
    if (d[0] == 4'd2 && d[1] > 4'd3) ok = 1'b0;
    if (d[2] > 4'd5 || d[3] > 4'd9) ok = 1'b0;
    if (d[4] > 4'd5 || d[5] > 4'd9) ok = 1'b0;
    return ok;
  endfunction

  // Ripple one second through HH:MM:SS, wrapping 23:59:59 to 00:00:00.
  function automatic digits_t sec_advance(digits_t d);
    logic [4:0] t0, t1, t2, t3, t4, t5;
    digits_t    r;
    t0 = {1'b0, d[0]};
    t1 = {1'b0, d[1]};
    t2 = {1'b0, d[2]};
    t3 = {1'b0, d[3]};
    t4 = {1'b0, d[4]};
    t5 = {1'b0, d[5]} + 5'd1;
    if (t5 > 5'd9) begin t5 = '0; t4 = t4 + 5'd1; end
    if (t4 > 5'd5) begin t4 = '0; t3 = t3 + 5'd1; end
    if (t3 > 5'd9) begin t3 = '0; t2 = t2 + 5'd1; end
    if (t2 > 5'd5) begin t2 = '0; t1 = t1 + 5'd1; end
    if (t1 > 5'd9) begin t1 = '0; t0 = t0 + 5'd1; end
    if (t0 >= 5'd2 && t1 >= 5'd4) begin t0 = '0; t1 = '0; end
    r[0] = t0[3:0];
    r[1] = t1[3:0];
    r[2] = t2[3:0];
    r[3] = t3[3:0];
    r[4] = t4[3:0];
    r[5] = t5[3:0];
    return r;
  endfunction

endpackage

>>> design/bcd_clock_with_alarm.sv
// Top level of the 24-hour BCD clock with alarm.
//
//   channel   direction   payload                     handshake
//   in_       input       in_item_t (action, digits)  in_valid / in_ready
//   out_      output      out_item_t (time, flags)    out_valid / out_ready
//   cfg_      input       ticks_per_second, 32 bits   cfg_valid / cfg_ready
//
// One item per cycle while the result is not stalled, through the input register, then
// one pass of decode, 32-bit prescaler increment and compare into the result
// register. Synchronous active-low reset clears time, alarm, prescaler,
// snooze and flags, and sets ticks_per_second to 1. A stalled result holds
// in the result register while the input register still takes one item.
module bcd_clock_with_alarm
  import bcdclk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TpsWidth-1:0] cfg_data
);

  logic [TpsWidth-1:0] tps_r;
  logic                s_valid;
  logic                s_take;
  in_item_t            s_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TpsWidth'(1);
    end else if (cfg_valid && cfg_ready) begin
      tps_r <= cfg_data;
    end
  end

  bcdclk_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_take   (s_take),
    .s_item   (s_item)
  );

  bcdclk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_take    (s_take),
    .s_item    (s_item),
    .tps       (tps_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/bcdclk_in_reg.sv
// Input register stage holding one accepted item for the clock core.
module bcdclk_in_reg
  import bcdclk_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     s_valid,
  input  logic     s_take,
  output in_item_t s_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // Refill in the same cycle the core takes the held item.
  assign in_ready  = !valid_r || s_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

>>> design/bcdclk_core.sv
// Clock state, item decode and result register of the BCD alarm clock.
module bcdclk_core
  import bcdclk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_take,
  input  in_item_t            s_item,
  input  logic [TpsWidth-1:0] tps,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  digits_t             time_r, time_nxt;
  digits_t             alarm_r, alarm_nxt;
  logic [TpsWidth-1:0] pre_r, pre_nxt, pre_inc;
  logic [SnzWidth-1:0] snz_r, snz_nxt;
  logic                tset_r, tset_nxt;
  logic                aon_r, aon_nxt;
  logic                hit_r, hit_nxt;
  logic                rej;
  digits_t             in_dig;
  digits_t             adv;
  logic                oval_r, oval_nxt;
  out_item_t           out_r, out_nxt;

  assign s_take  = s_valid && (!oval_r || out_ready);
  assign pre_inc = pre_r + 1'b1;
  assign adv     = sec_advance(time_r);
  assign in_dig  = {s_item.hour_tens, s_item.hour_units, s_item.minute_tens,
                    s_item.minute_units, s_item.second_tens, s_item.second_units};

  always_comb begin
    time_nxt  = time_r;
    alarm_nxt = alarm_r;
    pre_nxt   = pre_r;
    snz_nxt   = snz_r;
    tset_nxt  = tset_r;
    aon_nxt   = aon_r;
    hit_nxt   = hit_r;
    rej       = 1'b0;
    case (action_t'(s_item.action))
      ACT_TICK: begin
        if (pre_inc == tps) begin
          time_nxt = adv;
          pre_nxt  = '0;
          tset_nxt = 1'b1;
          if (snz_r != '0) snz_nxt = snz_r - 1'b1;
          if (aon_r && adv == alarm_r) hit_nxt = 1'b1;
        end else begin
          pre_nxt = pre_inc;
        end
      end
      ACT_SET_TIME: begin
        if (digits_ok(in_dig)) begin
          time_nxt = in_dig;
          tset_nxt = 1'b1;
        end else begin
          rej = 1'b1;
        end
      end
      ACT_SET_ALARM: begin
        if (digits_ok(in_dig)) begin
          alarm_nxt = in_dig;
          aon_nxt   = 1'b1;
        end else begin
          rej = 1'b1;
        end
      end
      ACT_ALARM_EN: aon_nxt = s_item.enable_value;
      ACT_SET_SNZ:  snz_nxt = s_item.snooze_seconds;
      default: ;
    endcase
  end

  always_comb begin
    out_nxt.now_hour_tens    = time_nxt[0];
    out_nxt.now_hour_units   = time_nxt[1];
    out_nxt.now_minute_tens  = time_nxt[2];
    out_nxt.now_minute_units = time_nxt[3];
    out_nxt.now_second_tens  = time_nxt[4];
    out_nxt.now_second_units = time_nxt[5];
    out_nxt.time_valid       = tset_nxt;
    out_nxt.alarm_enabled    = aon_nxt;
    out_nxt.ringing          = hit_nxt && (snz_nxt == '0) && aon_nxt;
    out_nxt.rejected         = rej;
  end

  assign oval_nxt = s_take || (oval_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      alarm_r <= '0;
      pre_r   <= '0;
      snz_r   <= '0;
      tset_r  <= 1'b0;
      aon_r   <= 1'b0;
      hit_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
      if (s_take) begin
        time_r  <= time_nxt;
        alarm_r <= alarm_nxt;
        pre_r   <= pre_nxt;
        snz_r   <= snz_nxt;
        tset_r  <= tset_nxt;
        aon_r   <= aon_nxt;
        hit_r   <= hit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = oval_r;
  assign out_data  = out_r;

endmodule

>>> design/bcdclk_chk.sv
// Port-level checker for the BCD alarm clock, bound to the top level.
module bcdclk_chk
  import bcdclk_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_ring_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ringing |-> out_data.alarm_enabled)
    else $error("ringing with alarm off");

  a_time_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.now_hour_tens <= 4'd2 && out_data.now_hour_units <= 4'd9
      && !(out_data.now_hour_tens == 4'd2 && out_data.now_hour_units > 4'd3)
      && out_data.now_minute_tens <= 4'd5 && out_data.now_minute_units <= 4'd9
      && out_data.now_second_tens <= 4'd5 && out_data.now_second_units <= 4'd9)
    else $error("time digits out of range");

  // Check only on the first edge out of reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bcd_clock_with_alarm bcdclk_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
